/* src/fac_pkg.sv */
// ----------------------------------------------------------------------------
// fac_pkg - shared types and constants for the frustum box culler
// Item modes, slot layout of the data word and the control struct that
// travels with every word down the chain of plane cells.
// ----------------------------------------------------------------------------
package fac_pkg;

    // fixed widths of the channel fields
    localparam int FIELD_BITS = 32;
    localparam int ROW_BITS   = 2;

    // six planes, three axes, six coordinate slots per word
    localparam int NUM_PLANES = 6;
    localparam int NUM_AXES   = 3;
    localparam int NUM_SLOTS  = 6;

    // slot of column 3 in a matrix row word; max corner starts here too
    localparam int W_SLOT     = 3;

    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_TEST = 1'b1
    } mode_t;

    // control that moves with each word from cell to cell
    typedef struct packed {
        logic                valid;
        mode_t               mode;
        logic [ROW_BITS-1:0] row;
        logic                vis;
    } fac_ctl_t;

endpackage

/* src/frustum_aabb_cull.sv */
// ----------------------------------------------------------------------------
// frustum_aabb_cull - view-frustum culling of axis-aligned boxes
// Row words load the view-projection matrix, box words are tested against
// the six planes derived from it and return one visible flag each.
// ----------------------------------------------------------------------------
// One word is accepted every cycle while the output is not stalled, row words
// and box words alike, and the result of a box comes out through six plane
// cells of two stages each (multiply, then sum and sign test) and an output register.
// Row words travel down the same chain and update each cell's plane in
// order, so a box always sees the matrix loaded before it. Row words give
// no result. The matrix reads as all zero after reset.
module frustum_aabb_cull #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [1:0]  s_row_index,
    input  logic [31:0] s_elem0,
    input  logic [31:0] s_elem1,
    input  logic [31:0] s_elem2,
    input  logic [31:0] s_elem3,
    input  logic [31:0] s_min_x,
    input  logic [31:0] s_min_y,
    input  logic [31:0] s_min_z,
    input  logic [31:0] s_max_x,
    input  logic [31:0] s_max_y,
    input  logic [31:0] s_max_z,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_visible
);
    import fac_pkg::*;

    localparam int TAKE = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;

    fac_ctl_t                              ctl   [NUM_PLANES+1];
    logic [NUM_SLOTS-1:0][COORD_BITS-1:0]  data  [NUM_PLANES+1];
    logic                                  ready [NUM_PLANES+1];
    fac_ctl_t                              entry_ctl;
    logic [NUM_SLOTS-1:0][COORD_BITS-1:0]  entry_data;
    logic                                  m_valid_reg, m_valid_next;
    logic                                  m_visible_reg, m_visible_next;

    // field to internal coordinate: cut to the coordinate width, zero-extended if wider
    function automatic logic [COORD_BITS-1:0] to_coord(input logic [FIELD_BITS-1:0] f);
        logic [COORD_BITS-1:0] c;
        if (COORD_BITS > FIELD_BITS) begin
            c = COORD_BITS'(f[TAKE-1:0]);
        end else begin
            c = COORD_BITS'($signed(f[TAKE-1:0]));
        end
        return c;
    endfunction

    // entry word: row elements or box corners in the slots
    always_comb begin
        entry_ctl.valid = s_valid;
        entry_ctl.mode  = mode_t'(s_mode);
        entry_ctl.row   = s_row_index;
        entry_ctl.vis   = 1'b1;
        if (mode_t'(s_mode) == MODE_LOAD) begin
            entry_data[0] = to_coord(s_elem0);
            entry_data[1] = to_coord(s_elem1);
            entry_data[2] = to_coord(s_elem2);
            entry_data[3] = to_coord(s_elem3);
            entry_data[4] = '0;
            entry_data[5] = '0;
        end else begin
            entry_data[0] = to_coord(s_min_x);
            entry_data[1] = to_coord(s_min_y);
            entry_data[2] = to_coord(s_min_z);
            entry_data[3] = to_coord(s_max_x);
            entry_data[4] = to_coord(s_max_y);
            entry_data[5] = to_coord(s_max_z);
        end
    end
    assign ctl[0]  = entry_ctl;
    assign data[0] = entry_data;
    assign s_ready = ready[0];

    // chain of plane cells: left, right, bottom, top, near, far
    for (genvar k = 0; k < NUM_PLANES; k++) begin : g_plane
        fac_plane_cell #(
            .COORD_BITS (COORD_BITS),
            .FRAC_BITS  (FRAC_BITS),
            .PLANE      (k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_ctl    (ctl[k]),
            .in_data   (data[k]),
            .in_ready  (ready[k]),
            .out_ctl   (ctl[k+1]),
            .out_data  (data[k+1]),
            .out_ready (ready[k+1])
        );
    end

    // output register, row words are retired here without a result
    assign ready[NUM_PLANES] = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next   = m_valid_reg && !m_ready;
        m_visible_next = m_visible_reg;
        if (ready[NUM_PLANES]) begin
            m_valid_next   = ctl[NUM_PLANES].valid && (ctl[NUM_PLANES].mode == MODE_TEST);
            m_visible_next = ctl[NUM_PLANES].vis;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_visible_reg <= m_visible_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_visible = m_visible_reg;

endmodule

/* src/fac_plane_cell.sv */
// ----------------------------------------------------------------------------
// fac_plane_cell - one frustum plane of the culling chain
// Holds the four coefficients of its plane. Row words update them in
// passing; box words get their positive vertex multiplied in the first
// stage and the plane distance summed and sign tested in the second.
// ----------------------------------------------------------------------------
module fac_plane_cell #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16,
    parameter int PLANE      = 0
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  fac_pkg::fac_ctl_t                               in_ctl,
    input  logic [fac_pkg::NUM_SLOTS-1:0][COORD_BITS-1:0]   in_data,
    output logic                                            in_ready,
    output fac_pkg::fac_ctl_t                               out_ctl,
    output logic [fac_pkg::NUM_SLOTS-1:0][COORD_BITS-1:0]   out_data,
    input  logic                                            out_ready
);
    import fac_pkg::*;

    localparam int AXIS = PLANE / 2;
    localparam int SUB  = PLANE % 2;
    localparam int CW   = COORD_BITS + 1;
    localparam int PW   = 2 * COORD_BITS + 1;
    localparam int DW   = CW + FRAC_BITS;
    localparam int SW   = ((PW > DW) ? PW : DW) + 2;

    logic [3:0][CW-1:0]                    coef_reg, coef_next;
    fac_ctl_t                              ctl1_reg, ctl1_next;
    fac_ctl_t                              ctl2_reg, ctl2_next;
    logic [NUM_SLOTS-1:0][COORD_BITS-1:0]  data1_reg, data2_reg;
    logic [NUM_AXES-1:0][PW-1:0]           prod_reg, prod_next;
    logic [CW-1:0]                         dcoef_reg;
    logic                                  ready1, ready2;
    logic                                  load_en;
    logic [CW-1:0]                         new_coef;
    logic [COORD_BITS-1:0]                 vtx;
    logic signed [SW-1:0]                  plane_dist;

    // stage handshake, each stage frees when empty or moving on
    assign ready2   = !ctl2_reg.valid || out_ready;
    assign ready1   = !ctl1_reg.valid || ready2;
    assign in_ready = ready1;

    // coefficient update from a passing row word
    assign load_en = in_ctl.valid && (in_ctl.mode == MODE_LOAD) && ready1;

    always_comb begin
        if (SUB != 0) begin
            new_coef = CW'($signed(in_data[W_SLOT])) - CW'($signed(in_data[AXIS]));
        end else begin
            new_coef = CW'($signed(in_data[W_SLOT])) + CW'($signed(in_data[AXIS]));
        end
        coef_next = coef_reg;
        if (load_en) begin
            coef_next[in_ctl.row] = new_coef;
        end
    end

    // positive vertex per axis and its product with the coefficient
    always_comb begin
        vtx = '0;
        for (int a = 0; a < NUM_AXES; a++) begin
            vtx = coef_reg[a][CW-1] ? in_data[a] : in_data[NUM_AXES + a];
            prod_next[a] = PW'($signed(coef_reg[a])) * PW'($signed(vtx));
        end
    end

    // plane distance scaled by the fraction, negative means outside
    assign plane_dist = SW'($signed(prod_reg[0])) + SW'($signed(prod_reg[1]))
                      + SW'($signed(prod_reg[2]))
                      + (SW'($signed(dcoef_reg)) <<< FRAC_BITS);

    // stage control next values
    always_comb begin
        ctl1_next = ready1 ? in_ctl : ctl1_reg;
        ctl2_next = ctl2_reg;
        if (ready2) begin
            ctl2_next     = ctl1_reg;
            ctl2_next.vis = ctl1_reg.vis && !plane_dist[SW-1];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= '0;
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end else begin
            coef_reg <= coef_next;
            ctl1_reg <= ctl1_next;
            ctl2_reg <= ctl2_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (ready1) begin
            data1_reg <= in_data;
            prod_reg  <= prod_next;
            dcoef_reg <= coef_reg[W_SLOT];
        end
        if (ready2) begin
            data2_reg <= data1_reg;
        end
    end

    assign out_ctl  = ctl2_reg;
    assign out_data = data2_reg;

    // a stalled first stage keeps its word
    a_stage1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl1_reg.valid && !ready2 |=> ctl1_reg.valid)
        else $error("plane cell dropped a stalled word");

    // a box already culled upstream stays culled
    a_cull_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl1_reg.valid && ready2 && !ctl1_reg.vis |=> !ctl2_reg.vis)
        else $error("plane cell revived a culled box");

    // coefficients change only when a row word enters
    a_coef_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        !load_en |=> $stable(coef_reg))
        else $error("plane coefficients changed without a row word");

endmodule
